// ----- design/assert_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- design/rgbbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rgbbr_pkg;

    localparam int NUM_COLORS_DEF   = 7;
    localparam int SINE_ENTRIES_DEF = 256;

    localparam logic [21:0] PHASE_STEP   = 22'd3417612;
    localparam logic [13:0] HOLD_BASE    = 14'd10000;
    localparam int          DIV_BITS     = 14;
    localparam logic [9:0]  PWM_TOP      = 10'd999;
    localparam logic [7:0]  BYTE_BREATHE = 8'h00;
    localparam logic [7:0]  BYTE_RAINBOW = 8'hFF;

    // Color levels already scaled from 0..255 to 0..999.
    localparam logic [9:0] LVL_0   = 10'd0;
    localparam logic [9:0] LVL_75  = 10'((75 * 999) / 255);
    localparam logic [9:0] LVL_130 = 10'((130 * 999) / 255);
    localparam logic [9:0] LVL_148 = 10'((148 * 999) / 255);
    localparam logic [9:0] LVL_165 = 10'((165 * 999) / 255);
    localparam logic [9:0] LVL_211 = 10'((211 * 999) / 255);
    localparam logic [9:0] LVL_255 = 10'((255 * 999) / 255);

    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT     = 4'd0;
    localparam step_t ST_APPLY    = 4'd1;
    localparam step_t ST_MUL      = 4'd2;
    localparam step_t ST_PHASE    = 4'd3;
    localparam step_t ST_INDEX    = 4'd4;
    localparam step_t ST_ROM      = 4'd5;
    localparam step_t ST_SCALE    = 4'd6;
    localparam step_t ST_EMIT_B   = 4'd7;
    localparam step_t ST_DIV_INIT = 4'd8;
    localparam step_t ST_DIV_STEP = 4'd9;
    localparam step_t ST_HOLD     = 4'd10;
    localparam step_t ST_EMIT_R   = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP         = 4'd0,
        OP_ACCEPT      = 4'd1,
        OP_APPLY       = 4'd2,
        OP_MUL         = 4'd3,
        OP_PHASE       = 4'd4,
        OP_INDEX       = 4'd5,
        OP_ROM         = 4'd6,
        OP_SCALE       = 4'd7,
        OP_EMIT_BREATH = 4'd8,
        OP_DIV_INIT    = 4'd9,
        OP_DIV_STEP    = 4'd10,
        OP_HOLD        = 4'd11,
        OP_EMIT_RAIN   = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_IN_VALID = 3'd2,
        COND_RAINBOW  = 3'd3,
        COND_DIV_MORE = 3'd4,
        COND_OUT_BUSY = 3'd5
    } cond_t;

    // One microcode word: take jump when cond holds, otherwise go to next.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jump;
        step_t next;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic rainbow;
        logic div_more;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [9:0] blue;
        logic [9:0] green;
        logic [9:0] red;
    } rgb_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        unique case (s)
            ST_WAIT:     w = '{OP_ACCEPT,      COND_IN_VALID, ST_APPLY,    ST_WAIT};
            ST_APPLY:    w = '{OP_APPLY,       COND_RAINBOW,  ST_DIV_INIT, ST_MUL};
            ST_MUL:      w = '{OP_MUL,         COND_NEVER,    ST_WAIT,     ST_PHASE};
            ST_PHASE:    w = '{OP_PHASE,       COND_NEVER,    ST_WAIT,     ST_INDEX};
            ST_INDEX:    w = '{OP_INDEX,       COND_NEVER,    ST_WAIT,     ST_ROM};
            ST_ROM:      w = '{OP_ROM,         COND_NEVER,    ST_WAIT,     ST_SCALE};
            ST_SCALE:    w = '{OP_SCALE,       COND_NEVER,    ST_WAIT,     ST_EMIT_B};
            ST_EMIT_B:   w = '{OP_EMIT_BREATH, COND_OUT_BUSY, ST_EMIT_B,   ST_WAIT};
            ST_DIV_INIT: w = '{OP_DIV_INIT,    COND_NEVER,    ST_WAIT,     ST_DIV_STEP};
            ST_DIV_STEP: w = '{OP_DIV_STEP,    COND_DIV_MORE, ST_DIV_STEP, ST_HOLD};
            ST_HOLD:     w = '{OP_HOLD,        COND_NEVER,    ST_WAIT,     ST_EMIT_R};
            ST_EMIT_R:   w = '{OP_EMIT_RAIN,   COND_OUT_BUSY, ST_EMIT_R,   ST_WAIT};
            default:     w = '{OP_NOP,         COND_ALWAYS,   ST_WAIT,     ST_WAIT};
        endcase
        return w;
    endfunction

    // Seven-entry color wheel; indexes past the table wrap around it.
    function automatic rgb_t rainbow_color(input logic [3:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0, 4'd7, 4'd14: c = '{LVL_0,   LVL_0,   LVL_255};
            4'd1, 4'd8, 4'd15: c = '{LVL_0,   LVL_165, LVL_255};
            4'd2, 4'd9:        c = '{LVL_0,   LVL_255, LVL_255};
            4'd3, 4'd10:       c = '{LVL_0,   LVL_255, LVL_0};
            4'd4, 4'd11:       c = '{LVL_255, LVL_0,   LVL_0};
            4'd5, 4'd12:       c = '{LVL_130, LVL_0,   LVL_75};
            default:           c = '{LVL_211, LVL_0,   LVL_148};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/rgbbr_useq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rgbbr_useq
    import rgbbr_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  taken;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_IN_VALID: taken = stat.in_valid;
            COND_RAINBOW:  taken = stat.rainbow;
            COND_DIV_MORE: taken = stat.div_more;
            COND_OUT_BUSY: taken = stat.out_busy;
            default:       taken = 1'b0;
        endcase
        step_next = taken ? ctrl.jump : ctrl.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_WAIT;
        else
            step_reg <= step_next;
    end

endmodule
`default_nettype wire

// ----- design/rgbbr_breath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rgbbr_breath
    import rgbbr_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  ctrl_t      ctrl,
    input  wire        clear,
    input  wire  [7:0] speed,
    output logic [9:0] level
);

    localparam int IW = $clog2(SINE_ENTRIES);
    localparam int PW = 30 + IW + 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Quarter-wave sine at the center of entry i, Q16, built in Q30 fixed point.
    function automatic logic [16:0] quarter_sine(input int i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] t;
        x  = ((64'(2 * i) + 64'd1) * HALF_PI_Q30) / 64'(2 * SINE_ENTRIES);
        x2 = (x * x) >> 30;
        s  = ONE_Q30;
        t  = ((x2 * s) >> 30) / 64'd110;
        s  = ONE_Q30 - t;
        t  = ((x2 * s) >> 30) / 64'd72;
        s  = ONE_Q30 - t;
        t  = ((x2 * s) >> 30) / 64'd42;
        s  = ONE_Q30 - t;
        t  = ((x2 * s) >> 30) / 64'd20;
        s  = ONE_Q30 - t;
        t  = ((x2 * s) >> 30) / 64'd6;
        s  = ONE_Q30 - t;
        s  = (x * s) >> 30;
        return 17'((s + 64'd8192) >> 14);
    endfunction

    logic [16:0] sine_rom [SINE_ENTRIES];

    for (genvar gi = 0; gi < SINE_ENTRIES; gi++)
    begin : g_rom
        assign sine_rom[gi] = quarter_sine(gi);
    end

    logic [31:0]   phase_reg;
    logic [29:0]   step_reg;
    logic [IW-1:0] idx_reg;
    logic [16:0]   sine_reg;
    logic [9:0]    level_reg;

    logic [PW-1:0] idx_prod;
    logic [IW-1:0] idx_raw;
    logic [17:0]   unit;
    logic [27:0]   scaled;

    assign idx_prod = PW'(phase_reg[29:0]) * PW'(SINE_ENTRIES);
    assign idx_raw  = idx_prod[30 +: IW];
    // Quadrants 1 and 3 run the table backwards; 2 and 3 take the lower half.
    assign unit     = phase_reg[31] ? (18'd65536 - 18'(sine_reg))
                                    : (18'd65536 + 18'(sine_reg));
    assign scaled   = 28'(unit) * 28'(PWM_TOP);
    assign level    = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (ctrl.op == OP_APPLY && clear)
            phase_reg <= '0;
        else if (ctrl.op == OP_PHASE)
            phase_reg <= phase_reg + 32'(step_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_MUL)
            step_reg <= 30'(speed) * 30'(PHASE_STEP);
        if (ctrl.op == OP_INDEX)
            idx_reg <= phase_reg[30] ? (IW'(SINE_ENTRIES - 1) - idx_raw) : idx_raw;
        if (ctrl.op == OP_ROM)
            sine_reg <= sine_rom[idx_reg];
        if (ctrl.op == OP_SCALE)
            level_reg <= scaled[26:17];
    end

endmodule
`default_nettype wire

// ----- design/rgbbr_rainbow.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rgbbr_rainbow
    import rgbbr_pkg::*;
#(
    parameter int NUM_COLORS = NUM_COLORS_DEF
)
(
    input  wire       clk,
    input  wire       rst_n,
    input  ctrl_t     ctrl,
    input  wire       clear,
    input  wire [7:0] speed,
    output logic      div_more,
    output rgb_t      color
);

    localparam int CIW = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;

    logic [13:0]    quo_reg;
    logic [7:0]     rem_reg;
    logic [3:0]     cnt_reg;
    logic [13:0]    hold_reg;
    logic [CIW-1:0] color_reg;

    logic [7:0]  divisor;
    logic [8:0]  trial;
    logic        fits;
    logic [13:0] hold_inc;
    logic        wrap;

    assign divisor  = (speed == 8'd0) ? 8'd1 : speed;
    // Restoring divide of the hold base by the speed, one quotient bit a step.
    assign trial    = {rem_reg, quo_reg[13]};
    assign fits     = trial >= {1'b0, divisor};
    assign div_more = cnt_reg != 4'd1;
    assign hold_inc = hold_reg + 14'd1;
    assign wrap     = hold_inc >= quo_reg;
    assign color    = rainbow_color(4'(color_reg));

    always_ff @(posedge clk)
    begin
        if (ctrl.op == OP_DIV_INIT)
        begin
            quo_reg <= HOLD_BASE;
            rem_reg <= '0;
            cnt_reg <= 4'(DIV_BITS);
        end
        else if (ctrl.op == OP_DIV_STEP)
        begin
            quo_reg <= {quo_reg[12:0], fits};
            rem_reg <= fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            color_reg <= '0;
        end
        else if (ctrl.op == OP_APPLY && clear)
        begin
            hold_reg  <= '0;
            color_reg <= '0;
        end
        else if (ctrl.op == OP_HOLD)
        begin
            if (wrap)
            begin
                hold_reg  <= '0;
                color_reg <= (color_reg == CIW'(NUM_COLORS - 1)) ? '0
                                                                  : color_reg + 1'b1;
            end
            else
            begin
                hold_reg <= hold_inc;
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/rgb_led_breathe_rainbow_pwm.sv -----
`timescale 1ns / 1ps
// Items step through the microcode: breathing items through the phase, sine index,
// ROM and scale steps, rainbow items through the 14-step restoring divide for the
// hold time and the hold step; an emit step waits while the output is stalled.
// The input is taken again once the result is in the output register.
// Reset (rst_n low, asynchronous) selects breathing, sets the speed to 1, clears
// the phase, hold count and color index, and empties the output register.
`default_nettype none
module rgb_led_breathe_rainbow_pwm
    import rgbbr_pkg::*;
#(
    parameter int NUM_COLORS   = NUM_COLORS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  wire  [0:0]  s_axis_tuser,  // [0] byte_valid
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [9:0] pwm_red, [19:10] pwm_green, [29:20] pwm_blue,
    // [37:30] reply_mode, [45:38] reply_speed, [47:46] zero
    output logic [47:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser   // [0] reply_valid
);

    ctrl_t ctrl;
    stat_t stat;

    logic       byte_valid_reg;
    logic [7:0] rx_byte_reg;
    logic       mode_reg;
    logic       mode_next;
    logic [7:0] speed_reg;
    logic [7:0] speed_next;
    logic       clear;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_user_reg;
    logic        out_busy;
    logic        emit;

    logic [9:0] breath_level;
    rgb_t       color;
    logic       div_more;
    logic [7:0] reply_mode;
    logic [7:0] reply_speed;

    assign s_axis_tready = ctrl.op == OP_ACCEPT;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign out_busy = out_valid_reg && !m_axis_tready;
    assign emit     = (ctrl.op == OP_EMIT_BREATH || ctrl.op == OP_EMIT_RAIN) && !out_busy;

    assign stat = '{in_valid: s_axis_tvalid, rainbow: mode_next,
                    div_more: div_more, out_busy: out_busy};

    // Mode bytes switch mode only when they differ; any other byte is the speed.
    always_comb
    begin
        mode_next  = mode_reg;
        speed_next = speed_reg;
        clear      = 1'b0;
        if (ctrl.op == OP_APPLY && byte_valid_reg)
        begin
            if (rx_byte_reg == BYTE_BREATHE || rx_byte_reg == BYTE_RAINBOW)
            begin
                if ((rx_byte_reg == BYTE_RAINBOW) != mode_reg)
                begin
                    mode_next = rx_byte_reg == BYTE_RAINBOW;
                    clear     = 1'b1;
                end
            end
            else
            begin
                speed_next = rx_byte_reg;
            end
        end
    end

    assign reply_mode  = !byte_valid_reg ? 8'h00 : (mode_reg ? BYTE_RAINBOW : BYTE_BREATHE);
    assign reply_speed = byte_valid_reg ? speed_reg : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            speed_reg     <= 8'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            speed_reg <= speed_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_valid_reg <= s_axis_tuser[0];
            rx_byte_reg    <= s_axis_tdata;
        end
        if (emit)
        begin
            out_user_reg <= byte_valid_reg;
            if (ctrl.op == OP_EMIT_BREATH)
                out_data_reg <= {2'b00, reply_speed, reply_mode,
                                 breath_level, breath_level, breath_level};
            else
                out_data_reg <= {2'b00, reply_speed, reply_mode,
                                 color.blue, color.green, color.red};
        end
    end

    rgbbr_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rgbbr_breath #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_breath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .clear (clear),
        .speed (speed_reg),
        .level (breath_level)
    );

    rgbbr_rainbow #(
        .NUM_COLORS (NUM_COLORS)
    ) u_rainbow
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .clear    (clear),
        .speed    (speed_reg),
        .div_more (div_more),
        .color    (color)
    );

endmodule
`default_nettype wire

// ----- design/rgbbr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rgbbr_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [47:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser
);

    // Only one item is in flight: the input closes right after an accept.
    `AST_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Without a received byte the echo fields stay zero.
    `AST_IMPL(a_quiet_echo, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[45:30] == 16'h0000)

    // An echoed mode is always one of the two mode bytes.
    `AST_IMPL(a_mode_code, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[37:30] == 8'h00 || m_axis_tdata[37:30] == 8'hFF)

    // A stalled result keeps its payload.
    `AST_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind rgb_led_breathe_rainbow_pwm rgbbr_checker u_rgbbr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
